// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the RTL, included by euclidean_distance_3d_core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also runs through reset.
`define ED_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/edist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edist_pkg
// Pipeline constants for the 3D distance core.
// ----------------------------------------------------------------------------
package edist_pkg;

  // Register stages inside each coordinate lane (abs difference, square).
  localparam int unsigned LANE_STAGES  = 2;
  // Register stage for the sum of the three lane squares.
  localparam int unsigned MERGE_STAGES = 1;
  // Register stage after the root pipeline that applies rounding.
  localparam int unsigned ROUND_STAGES = 1;
  // One lane per spatial axis.
  localparam int unsigned NUM_LANES    = 3;

endpackage

// ===== rtl/edist_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edist_lane
// One axis: registered absolute difference, then registered square.
// ----------------------------------------------------------------------------
module edist_lane #(
  parameter int unsigned COORD_BITS = 30
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_BITS-1:0]  coord_a,
  input  logic signed [COORD_BITS-1:0]  coord_b,
  output logic [2*COORD_BITS+1:0]       square
);

  localparam int unsigned MW  = COORD_BITS + 1;
  localparam int unsigned SQW = 2 * MW;

  logic signed [MW-1:0] diff;
  logic [MW-1:0]        mag_nxt;
  logic [MW-1:0]        mag_r;
  logic [SQW-1:0]       sq_nxt;
  logic [SQW-1:0]       sq_r;

  // difference cannot overflow one extra bit
  assign diff    = {coord_a[COORD_BITS-1], coord_a} - {coord_b[COORD_BITS-1], coord_b};
  assign mag_nxt = diff[MW-1] ? (~diff + 1'b1) : diff;
  assign sq_nxt  = mag_r * mag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      sq_r  <= sq_nxt;
    end
  end

  assign square = sq_r;

endmodule

// ===== rtl/edist_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edist_sqrt
// Pipelined restoring square root, one root bit per stage, then rounding
// to nearest in a final register.
// ----------------------------------------------------------------------------
module edist_sqrt #(
  parameter int unsigned ROOT_BITS = 31
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2*ROOT_BITS-1:0]    radicand,
  output logic [ROOT_BITS-1:0]      root
);

  localparam int unsigned SW = 2 * ROOT_BITS;
  localparam int unsigned TW = SW + 1;

  // stage k holds partial root q and remainder n - q*q
  logic [ROOT_BITS-1:0] q_w   [ROOT_BITS+1];
  logic [SW-1:0]        rem_w [ROOT_BITS+1];
  logic [ROOT_BITS-1:0] q_r   [ROOT_BITS];
  logic [SW-1:0]        rem_r [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r;
  logic [ROOT_BITS-1:0] root_nxt;

  assign q_w[0]   = '0;
  assign rem_w[0] = radicand;

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    localparam int unsigned BIT = ROOT_BITS - 1 - k;
    logic [TW-1:0]        trial;
    logic                 take;
    logic [SW-1:0]        rem_nxt;
    logic [ROOT_BITS-1:0] q_nxt;

    // (q + 2^BIT)^2 - q^2
    assign trial   = (TW'(q_w[k]) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign take    = {1'b0, rem_w[k]} >= trial;
    assign rem_nxt = take ? SW'({1'b0, rem_w[k]} - trial) : rem_w[k];
    assign q_nxt   = take ? (q_w[k] | (ROOT_BITS'(1) << BIT)) : q_w[k];

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= q_nxt;
        rem_r[k] <= rem_nxt;
      end
    end

    assign q_w[k+1]   = q_r[k];
    assign rem_w[k+1] = rem_r[k];
  end

  // round up when remainder exceeds the floor root
  assign root_nxt = q_w[ROOT_BITS]
                  + ROOT_BITS'(rem_w[ROOT_BITS] > SW'(q_w[ROOT_BITS]));

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root_nxt;
    end
  end

  assign root = root_r;

endmodule

// ===== rtl/euclidean_distance_3d_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_distance_3d_core
// Rounded spatial distance and time difference of two space-time points.
// ----------------------------------------------------------------------------
// Usage:
//  - Input request: in_valid/in_ready with two points (x, y, z, time each).
//    Zero for the second point gives the vector length.
//  - Result request: out_valid/out_ready with out_distance (distance rounded
//    to nearest integer) and out_time_delta (first time minus second time).
//  - Pipeline from acceptance to out_valid: 2 lane stages, 1 merge add,
//    COORD_BITS + 1 root stages (one root bit per stage) and 1 rounding stage.
//  - Throughput: one request per cycle while the output is not stalled. Every stage is a register and the
//    root is fully pipelined, so nothing is shared between requests.
//  - Stall: when out_valid is high and out_ready low the whole pipeline
//    holds and in_ready drops; a waiting result is never overwritten.
//    With no result waiting, in_ready stays high.
//  - Reset (rst_n low, synchronous) clears all stage valid bits; datapath
//    registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euclidean_distance_3d_core
  import edist_pkg::*;
#(
  parameter int unsigned COORD_BITS = 30,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input request
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_first_x,
  input  logic signed [COORD_BITS-1:0] in_first_y,
  input  logic signed [COORD_BITS-1:0] in_first_z,
  input  logic signed [TIME_BITS-1:0]  in_first_time,
  input  logic signed [COORD_BITS-1:0] in_second_x,
  input  logic signed [COORD_BITS-1:0] in_second_y,
  input  logic signed [COORD_BITS-1:0] in_second_z,
  input  logic signed [TIME_BITS-1:0]  in_second_time,
  // result request
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COORD_BITS:0]          out_distance,
  output logic signed [TIME_BITS:0]    out_time_delta
);

  localparam int unsigned ROOT_BITS = COORD_BITS + 1;
  localparam int unsigned SW        = 2 * ROOT_BITS;
  localparam int unsigned LAT       = LANE_STAGES + MERGE_STAGES + ROOT_BITS
                                    + ROUND_STAGES;

  logic                        pipe_en;
  logic                        vld_r [LAT];
  logic signed [TIME_BITS:0]   td_r  [LAT];
  logic signed [TIME_BITS:0]   td_nxt;

  logic signed [COORD_BITS-1:0] lane_a [NUM_LANES];
  logic signed [COORD_BITS-1:0] lane_b [NUM_LANES];
  logic [SW-1:0]                lane_sq [NUM_LANES];
  logic [SW-1:0]                sum_nxt;
  logic [SW-1:0]                sum_r;

  // Whole pipeline advances unless the output register holds an untaken result.
  assign pipe_en  = !vld_r[LAT-1] || out_ready;
  assign in_ready = pipe_en;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LAT; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (pipe_en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < LAT; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // Time difference, carried alongside the distance
  assign td_nxt = {in_first_time[TIME_BITS-1], in_first_time}
                - {in_second_time[TIME_BITS-1], in_second_time};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      td_r[0] <= td_nxt;
      for (int s = 1; s < LAT; s++) begin
        td_r[s] <= td_r[s-1];
      end
    end
  end

  // One lane per axis
  assign lane_a[0] = in_first_x;
  assign lane_a[1] = in_first_y;
  assign lane_a[2] = in_first_z;
  assign lane_b[0] = in_second_x;
  assign lane_b[1] = in_second_y;
  assign lane_b[2] = in_second_z;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    edist_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (pipe_en),
      .coord_a (lane_a[l]),
      .coord_b (lane_b[l]),
      .square  (lane_sq[l])
    );
  end

  // Merge: sum of three squares stays below 2^SW
  assign sum_nxt = lane_sq[0] + lane_sq[1] + lane_sq[2];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sum_r <= sum_nxt;
    end
  end

  edist_sqrt #(
    .ROOT_BITS (ROOT_BITS)
  ) u_sqrt (
    .clk      (clk),
    .en       (pipe_en),
    .radicand (sum_r),
    .root     (out_distance)
  );

  assign out_valid      = vld_r[LAT-1];
  assign out_time_delta = td_r[LAT-1];

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `ED_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with no result pending")
  `ED_ASSERT(a_no_lost_result, (vld_r[LAT-2] && pipe_en) |=> out_valid, "request lost at output stage")
  `ED_ASSERT_RST(a_reset_clears, $past(!rst_n) |-> !out_valid, "result valid straight after reset")

endmodule
